@@ sv/xcfr_pkg.sv @@
// Shared types and constants for the XOR-checked frame receiver.
// No dependencies; used by every module of the block but the queue.
package xcfr_pkg;

    localparam int CMD_W         = 2;
    localparam int BYTE_W        = 8;
    localparam int TICK_W        = 32;
    localparam int LEN_OUT_W     = 6;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 16;

    // Shortest stored run at which a tail byte triggers a check.
    localparam int MIN_CHECK_LEN = 5;
    // Checksum span ends this many bytes past the declared data length.
    localparam int SPAN_EXTRA    = 3;
    // Position of the length byte in a frame.
    localparam int LEN_POS       = 2;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd100;

    typedef enum logic [CMD_W-1:0] {
        CMD_ARM  = 2'd0,
        CMD_BYTE = 2'd1,
        CMD_TICK = 2'd2
    } t_cmd;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_HEAD    = 2'd0,
        REG_TAIL    = 2'd1,
        REG_TIMEOUT = 2'd2
    } t_reg;

    typedef enum logic {
        JOB_FRAME   = 1'b0,
        JOB_TIMEOUT = 1'b1
    } t_job_kind;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_FRAME = 1'b1
    } t_bk_state;

endpackage

@@ sv/xcfr_front.sv @@
// Front end: config registers, input word decode, hunt/store/check logic.
// Issues store writes and result jobs. Depends on xcfr_pkg.
module xcfr_front #(
    parameter int DEPTH = 64,
    parameter int FW    = $clog2(DEPTH + 1),
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [xcfr_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [xcfr_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_accept,
    input  logic [xcfr_pkg::CMD_W-1:0]        i_cmd,
    input  logic [xcfr_pkg::BYTE_W-1:0]       i_rx_byte,
    input  logic                              i_q_full,
    input  logic                              i_frame_done,
    output logic                              o_ready,
    output logic                              o_wr_en,
    output logic [AW-1:0]                     o_wr_addr,
    output logic [xcfr_pkg::BYTE_W-1:0]       o_wr_data,
    output logic                              o_push,
    output logic [FW:0]                       o_push_job
);

    logic [xcfr_pkg::BYTE_W-1:0] r_head, r_tail;
    logic [xcfr_pkg::TICK_W-1:0] r_timeout;
    logic                        r_armed, n_armed;
    logic                        r_in_frame, n_in_frame;
    logic [FW-1:0]               r_fill, n_fill;
    logic [xcfr_pkg::BYTE_W-1:0] r_decl, n_decl;
    logic [xcfr_pkg::BYTE_W-1:0] r_prev, n_prev;
    logic [xcfr_pkg::BYTE_W-1:0] r_acc, n_acc;
    logic [xcfr_pkg::TICK_W-1:0] r_elapsed, n_elapsed;
    logic                        r_lock, n_lock;

    logic [FW-1:0]               fill_inc;
    logic                        in_span;
    logic [xcfr_pkg::BYTE_W-1:0] acc_next;
    logic [xcfr_pkg::TICK_W-1:0] elapsed_inc;
    logic                        timed_out;
    xcfr_pkg::t_job_kind         push_kind;
    logic [FW-1:0]               push_len;

    // Store holds the frame being drained until the back end reports done.
    assign o_ready = !r_lock && !i_q_full;

    assign fill_inc  = r_fill + FW'(1);
    // Positions 1 and 2 are always in the span; later ones up to decl + 2.
    assign in_span   = (r_fill <= FW'(xcfr_pkg::LEN_POS))
                    || (10'(r_fill) < (10'(r_decl) + 10'(xcfr_pkg::SPAN_EXTRA)));
    assign acc_next  = in_span ? (r_acc ^ i_rx_byte) : r_acc;
    assign elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + 32'd1;
    assign timed_out = elapsed_inc >= r_timeout;

    assign o_push_job = {push_kind, push_len};

    always_comb begin
        n_armed    = r_armed;
        n_in_frame = r_in_frame;
        n_fill     = r_fill;
        n_decl     = r_decl;
        n_prev     = r_prev;
        n_acc      = r_acc;
        n_elapsed  = r_elapsed;
        n_lock     = r_lock;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_fill[AW-1:0];
        o_wr_data  = i_rx_byte;
        o_push     = 1'b0;
        push_kind  = xcfr_pkg::JOB_FRAME;
        push_len   = fill_inc;

        if (i_frame_done) begin
            n_lock = 1'b0;
        end

        if (i_accept) begin
            case (xcfr_pkg::t_cmd'(i_cmd))
                xcfr_pkg::CMD_ARM: begin
                    n_armed    = 1'b1;
                    n_elapsed  = '0;
                    n_in_frame = 1'b0;
                    n_fill     = '0;
                    n_decl     = '0;
                    n_prev     = '0;
                    n_acc      = '0;
                end
                xcfr_pkg::CMD_BYTE: begin
                    if (r_armed) begin
                        if (!r_in_frame) begin
                            if (i_rx_byte == r_head) begin
                                o_wr_en    = 1'b1;
                                o_wr_addr  = '0;
                                n_fill     = FW'(1);
                                n_in_frame = 1'b1;
                                n_prev     = i_rx_byte;
                                n_acc      = '0;
                            end
                        end else if (r_fill >= FW'(DEPTH)) begin
                            n_in_frame = 1'b0;
                        end else begin
                            o_wr_en = 1'b1;
                            n_fill  = fill_inc;
                            n_acc   = acc_next;
                            if (r_fill == FW'(xcfr_pkg::LEN_POS)) begin
                                n_decl = i_rx_byte;
                            end
                            if (fill_inc >= FW'(DEPTH)) begin
                                // store full: drop and hunt again
                                n_in_frame = 1'b0;
                            end else if (i_rx_byte == r_tail
                                         && fill_inc >= FW'(xcfr_pkg::MIN_CHECK_LEN)) begin
                                n_in_frame = 1'b0;
                                if (acc_next == r_prev) begin
                                    o_push  = 1'b1;
                                    n_armed = 1'b0;
                                    n_lock  = 1'b1;
                                end else begin
                                    n_prev = i_rx_byte;
                                end
                            end else begin
                                n_prev = i_rx_byte;
                            end
                        end
                    end
                end
                xcfr_pkg::CMD_TICK: begin
                    if (r_armed) begin
                        n_elapsed = elapsed_inc;
                        if (timed_out) begin
                            o_push     = 1'b1;
                            push_kind  = xcfr_pkg::JOB_TIMEOUT;
                            push_len   = '0;
                            n_armed    = 1'b0;
                            n_in_frame = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_timeout <= xcfr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            case (xcfr_pkg::t_reg'(i_cfg_addr))
                xcfr_pkg::REG_HEAD:    r_head    <= i_cfg_wdata[xcfr_pkg::BYTE_W-1:0];
                xcfr_pkg::REG_TAIL:    r_tail    <= i_cfg_wdata[xcfr_pkg::BYTE_W-1:0];
                xcfr_pkg::REG_TIMEOUT: r_timeout <= i_cfg_wdata[xcfr_pkg::TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_in_frame <= 1'b0;
            r_fill     <= '0;
            r_decl     <= '0;
            r_prev     <= '0;
            r_acc      <= '0;
            r_elapsed  <= '0;
            r_lock     <= 1'b0;
        end else begin
            r_armed    <= n_armed;
            r_in_frame <= n_in_frame;
            r_fill     <= n_fill;
            r_decl     <= n_decl;
            r_prev     <= n_prev;
            r_acc      <= n_acc;
            r_elapsed  <= n_elapsed;
            r_lock     <= n_lock;
        end
    end

endmodule

@@ sv/xcfr_queue.sv @@
// Two-entry job queue between front and back end.
// No package dependencies.
module xcfr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ sv/xcfr_back.sv @@
// Back end: frame store memory and result emitter with output register.
// Drains one job at a time from the queue. Depends on xcfr_pkg.
module xcfr_back #(
    parameter int DEPTH = 64,
    parameter int FW    = $clog2(DEPTH + 1),
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [AW-1:0]                      i_wr_addr,
    input  logic [xcfr_pkg::BYTE_W-1:0]        i_wr_data,
    input  logic                               i_q_valid,
    input  logic [FW:0]                        i_q_job,
    output logic                               o_q_pop,
    output logic                               o_frame_done,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_out_status,
    output logic [xcfr_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                               o_out_last,
    output logic [xcfr_pkg::LEN_OUT_W-1:0]     o_out_len
);

    logic [xcfr_pkg::BYTE_W-1:0] r_mem [DEPTH];

    xcfr_pkg::t_bk_state r_state, n_state;

    logic [FW-1:0]               r_len;
    logic [FW-1:0]               r_rd_idx;
    logic                        r_pend;
    logic                        r_pend_last;
    logic [xcfr_pkg::BYTE_W-1:0] r_rd_data;

    logic                        r_out_valid;
    logic                        r_out_status;
    logic [xcfr_pkg::BYTE_W-1:0] r_out_byte;
    logic                        r_out_last;
    logic [xcfr_pkg::LEN_OUT_W-1:0] r_out_len;

    xcfr_pkg::t_job_kind job_kind;
    logic [FW-1:0]       job_len;
    logic                can_load;
    logic                load_byte;
    logic                load_tmo;
    logic                issue;
    logic                start;
    logic                done;

    assign job_kind = xcfr_pkg::t_job_kind'(i_q_job[FW]);
    assign job_len  = i_q_job[FW-1:0];
    assign can_load = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            xcfr_pkg::BK_IDLE:  if (start) n_state = xcfr_pkg::BK_FRAME;
            xcfr_pkg::BK_FRAME: if (done)  n_state = xcfr_pkg::BK_IDLE;
            default:            n_state = xcfr_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop   = 1'b0;
        start     = 1'b0;
        load_tmo  = 1'b0;
        load_byte = 1'b0;
        issue     = 1'b0;
        done      = 1'b0;
        case (r_state)
            xcfr_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    if (job_kind == xcfr_pkg::JOB_FRAME) begin
                        o_q_pop = 1'b1;
                        start   = 1'b1;
                    end else if (can_load) begin
                        o_q_pop  = 1'b1;
                        load_tmo = 1'b1;
                    end
                end
            end
            xcfr_pkg::BK_FRAME: begin
                // read stage runs one ahead of the output register
                load_byte = r_pend && can_load;
                issue     = (r_rd_idx < r_len) && (!r_pend || load_byte);
                done      = (r_rd_idx == r_len) && !r_pend;
            end
            default: begin
            end
        endcase
    end

    assign o_frame_done = done;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (issue) begin
            r_rd_data   <= r_mem[r_rd_idx[AW-1:0]];
            r_pend_last <= (r_rd_idx + FW'(1)) == r_len;
        end
        if (start) begin
            r_len <= job_len;
        end
        if (load_byte) begin
            r_out_status <= 1'b0;
            r_out_byte   <= r_rd_data;
            r_out_last   <= r_pend_last;
            r_out_len    <= xcfr_pkg::LEN_OUT_W'(r_len);
        end else if (load_tmo) begin
            r_out_status <= 1'b1;
            r_out_byte   <= '0;
            r_out_last   <= 1'b1;
            r_out_len    <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xcfr_pkg::BK_IDLE;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start) begin
                r_rd_idx <= '0;
            end else if (issue) begin
                r_rd_idx <= r_rd_idx + FW'(1);
            end
            if (issue) begin
                r_pend <= 1'b1;
            end else if (load_byte) begin
                r_pend <= 1'b0;
            end
            if (load_byte || load_tmo) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_byte   = r_out_byte;
    assign o_out_last   = r_out_last;
    assign o_out_len    = r_out_len;

endmodule

@@ sv/xor_checked_frame_receiver.sv @@
// Top level of the XOR-checked frame receiver: front end, job queue, back end.
// Depends on xcfr_pkg, xcfr_front, xcfr_queue, xcfr_back.
//
// Usage:
//   Input stream words carry a command (arm, received byte, tick) and a byte.
//   A frame HEAD | CMD | LEN | DATA | XOR | TAIL whose XOR checks out is sent
//   on the output stream, one word per stored byte, head first, tlast on the
//   final byte; a timeout is one word with tuser set and tlast high.
//   Config registers (head, tail, timeout ticks) are written through the
//   plain write port while the block is idle.
// Flow:
//   The front end takes one input word per cycle while tready is high.
//   A frame that passes its check goes as a job through the queue; the back
//   end reads its bytes from the single-read-port store into the output
//   register, one per cycle while the output is not stalled. A timeout job
//   goes from the queue straight into the output register.
// Reset: synchronous, active low; the receiver comes up disarmed with the
//   registers at head 0, tail 0, timeout 100. The store is not cleared.
// Stalls: a held output word keeps the emitter waiting; up to two timeout
//   jobs queue up behind it before tready drops. A passed frame drops tready
//   at once until its last byte has left the store.
module xor_checked_frame_receiver #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [xcfr_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [xcfr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [1:0] cmd, [9:2] rx_byte, [15:10] zero
    input  logic [xcfr_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [7:0] frame_byte, [13:8] frame_length, [15:14] zero
    output logic [xcfr_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // [0] status
    output logic                                 o_m_axis_tuser,
    output logic                                 o_m_axis_tlast
);

    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);

    logic                                 accept;
    logic                                 q_full;
    logic                                 q_valid;
    logic                                 q_pop;
    logic                                 push;
    logic [FW:0]                          push_job;
    logic [FW:0]                          q_job;
    logic                                 frame_done;
    logic                                 wr_en;
    logic [AW-1:0]                        wr_addr;
    logic [xcfr_pkg::BYTE_W-1:0]          wr_data;
    logic [xcfr_pkg::BYTE_W-1:0]          out_byte;
    logic [xcfr_pkg::LEN_OUT_W-1:0]       out_len;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    xcfr_front #(
        .DEPTH (BUFFER_DEPTH),
        .FW    (FW),
        .AW    (AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_cmd        (i_s_axis_tdata[xcfr_pkg::CMD_W-1:0]),
        .i_rx_byte    (i_s_axis_tdata[xcfr_pkg::CMD_W +: xcfr_pkg::BYTE_W]),
        .i_q_full     (q_full),
        .i_frame_done (frame_done),
        .o_ready      (o_s_axis_tready),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_push       (push),
        .o_push_job   (push_job)
    );

    xcfr_queue #(
        .WIDTH (FW + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_job)
    );

    xcfr_back #(
        .DEPTH (BUFFER_DEPTH),
        .FW    (FW),
        .AW    (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_q_valid    (q_valid),
        .i_q_job      (q_job),
        .o_q_pop      (q_pop),
        .o_frame_done (frame_done),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_status (o_m_axis_tuser),
        .o_out_byte   (out_byte),
        .o_out_last   (o_m_axis_tlast),
        .o_out_len    (out_len)
    );

    assign o_m_axis_tdata = {2'b00, out_len, out_byte};

endmodule

@@ bench/xor_checked_frame_receiver_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for xor_checked_frame_receiver: directed table, then random
// frame traffic under four idle/stall mixes. Needs xcfr_pkg and the RTL only.
module xor_checked_frame_receiver_tb;

    localparam int STORE_DEPTH = 64;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 12;
    // Command code with no meaning; the block must ignore it.
    localparam logic [xcfr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic              status;
        logic [7:0]        fbyte;
        logic              last;
        logic [5:0]        flen;
    } t_frame_word;

    typedef struct packed {
        logic [xcfr_pkg::CMD_W-1:0] cmd;
        logic [7:0]                 rx;
        logic                       typed;
        t_frame_word                word;
    } t_stim_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                cfg_en = 1'b0;
    logic [xcfr_pkg::CFG_ADDR_W-1:0]     cfg_addr = '0;
    logic [xcfr_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    logic                                s_valid = 1'b0;
    logic [xcfr_pkg::IN_TDATA_W-1:0]     s_data = '0;
    logic                                m_ready = 1'b0;
    logic                                o_s_axis_tready;
    logic                                o_m_axis_tvalid;
    logic [xcfr_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata;
    logic                                o_m_axis_tuser;
    logic                                o_m_axis_tlast;

    xor_checked_frame_receiver #(.BUFFER_DEPTH(STORE_DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [7:0]                  rx_store [STORE_DEPTH];
    logic [6:0]                  rx_fill = '0;
    logic                        rx_in_frame = 1'b0;
    logic                        rx_armed = 1'b0;
    logic [7:0]                  rx_prev = '0;
    logic [7:0]                  rx_decl_len = '0;
    logic [xcfr_pkg::TICK_W-1:0] rx_elapsed = '0;
    logic [7:0]                  cfg_head = 8'd0;
    logic [7:0]                  cfg_tail = 8'd0;
    logic [xcfr_pkg::TICK_W-1:0] cfg_timeout = xcfr_pkg::TIMEOUT_RESET;

    t_frame_word frame_words_due[$];
    t_stim_row   stim_rows[$];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          phase_words = 0;
    int          errors = 0;

    function automatic void predict_receiver(logic [xcfr_pkg::CMD_W-1:0] c, logic [7:0] b,
                                             bit record);
        int span_end;
        int i;
        logic [7:0] acc;
        if (c == xcfr_pkg::CMD_ARM) begin
            rx_armed = 1'b1;
            rx_elapsed = '0;
            rx_in_frame = 1'b0;
            rx_fill = '0;
            rx_decl_len = '0;
            rx_prev = '0;
        end else if (rx_armed && c == xcfr_pkg::CMD_BYTE) begin
            if (!rx_in_frame) begin
                if (b == cfg_head) begin
                    rx_store[0] = b;
                    rx_fill = 7'd1;
                    rx_in_frame = 1'b1;
                    rx_prev = b;
                end
            end else if (rx_fill >= STORE_DEPTH) begin
                rx_in_frame = 1'b0;
            end else begin
                rx_store[rx_fill[5:0]] = b;
                if (rx_fill == xcfr_pkg::LEN_POS)
                    rx_decl_len = b;
                rx_fill = rx_fill + 7'd1;
                if (rx_fill >= STORE_DEPTH) begin
                    rx_in_frame = 1'b0;
                end else if (b == cfg_tail && rx_fill >= xcfr_pkg::MIN_CHECK_LEN) begin
                    // span is cmd, len and data; clipped to what has been stored
                    span_end = rx_decl_len + xcfr_pkg::SPAN_EXTRA;
                    if (span_end > rx_fill)
                        span_end = rx_fill;
                    acc = '0;
                    for (i = 1; i < span_end; i++)
                        acc ^= rx_store[i];
                    if (acc == rx_prev) begin
                        for (i = 0; i < rx_fill; i++)
                            if (record)
                                frame_words_due.push_back({xcfr_pkg::JOB_FRAME,
                                    rx_store[i], (i == rx_fill - 1), rx_fill[5:0]});
                        rx_armed = 1'b0;
                    end else begin
                        rx_prev = b;
                    end
                    rx_in_frame = 1'b0;
                end else begin
                    rx_prev = b;
                end
            end
        end else if (rx_armed && c == xcfr_pkg::CMD_TICK) begin
            if (rx_elapsed != '1)
                rx_elapsed = rx_elapsed + 1'b1;
            if (rx_elapsed >= cfg_timeout) begin
                if (record)
                    frame_words_due.push_back({xcfr_pkg::JOB_TIMEOUT, 8'h00, 1'b1, 6'd0});
                rx_armed = 1'b0;
                rx_in_frame = 1'b0;
            end
        end
    endfunction

    // Offer one word; a typed row replaces the predicted words with its own.
    task automatic push_word(input logic [xcfr_pkg::CMD_W-1:0] c, input logic [7:0] b,
                             input bit typed, input t_frame_word word);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data <= {6'd0, b, c};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        predict_receiver(c, b, !typed);
        if (typed)
            frame_words_due.push_back(word);
        phase_words++;
    endtask

    task automatic send(input logic [xcfr_pkg::CMD_W-1:0] c, input logic [7:0] b);
        push_word(c, b, 1'b0, '0);
    endtask

    task automatic cfg_write(input xcfr_pkg::t_reg idx,
                             input logic [xcfr_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_en <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            xcfr_pkg::REG_HEAD:    cfg_head = val[7:0];
            xcfr_pkg::REG_TAIL:    cfg_tail = val[7:0];
            xcfr_pkg::REG_TIMEOUT: cfg_timeout = val;
            default: ;
        endcase
    endtask

    // Wait until every expected word is out and the block has gone quiet.
    task automatic settle();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (frame_words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One armed hunt: optional noise, a frame with random content, maybe ticks.
    task automatic send_frame_run();
        int len;
        int n_data;
        int i;
        logic [7:0] c;
        logic [7:0] d;
        logic [7:0] x;
        if ($urandom_range(3) == 0)
            send(2'($urandom_range(3)), 8'($urandom_range(255)));
        if ($urandom_range(9) != 0)
            send(xcfr_pkg::CMD_ARM, 8'($urandom_range(255)));
        repeat ($urandom_range(2)) send(xcfr_pkg::CMD_BYTE, 8'($urandom_range(255)));
        case ($urandom_range(19))
            18, 19:         len = $urandom_range(40, 62);
            15, 16, 17:     len = $urandom_range(7, 20);
            default:        len = $urandom_range(6);
        endcase
        n_data = len;
        // short data makes the checksum span run past the stored bytes
        if ($urandom_range(9) == 0)
            n_data = $urandom_range(len);
        c = 8'($urandom_range(255));
        send(xcfr_pkg::CMD_BYTE, cfg_head);
        send(xcfr_pkg::CMD_BYTE, c);
        send(xcfr_pkg::CMD_BYTE, len[7:0]);
        x = c ^ len[7:0];
        for (i = 0; i < n_data; i++) begin
            d = 8'($urandom_range(255));
            if (d == cfg_tail)
                d = ~d;
            x ^= d;
            send(xcfr_pkg::CMD_BYTE, d);
        end
        if ($urandom_range(7) == 0)
            x ^= 8'(1 << $urandom_range(7));
        send(xcfr_pkg::CMD_BYTE, x);
        send(xcfr_pkg::CMD_BYTE, cfg_tail);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 4)) send(xcfr_pkg::CMD_TICK, 8'($urandom_range(255)));
    endtask

    task automatic run_phase(input logic [7:0] head, input logic [7:0] tail,
                             input logic [xcfr_pkg::TICK_W-1:0] tmo, input int idle_pct,
                             input int stall, input int words);
        settle();
        cfg_write(xcfr_pkg::REG_HEAD, {24'd0, head});
        cfg_write(xcfr_pkg::REG_TAIL, {24'd0, tail});
        cfg_write(xcfr_pkg::REG_TIMEOUT, tmo);
        @(negedge i_clk);
        cfg_en <= 1'b0;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        phase_words = 0;
        while (phase_words < words)
            send_frame_run();
    endtask

    always @(negedge i_clk)
        m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        t_frame_word want;
        t_frame_word got;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got = {o_m_axis_tuser, o_m_axis_tdata[7:0], o_m_axis_tlast,
                   o_m_axis_tdata[13:8]};
            if (frame_words_due.size() == 0) begin
                if (errors < 10)
                    $display("unexpected word: st=%0d byte=%02h last=%0d len=%0d",
                             got.status, got.fbyte, got.last, got.flen);
                errors++;
            end else begin
                want = frame_words_due.pop_front();
                if (got !== want) begin
                    if (errors < 10) begin
                        $display("mismatch: exp st=%0d byte=%02h last=%0d len=%0d",
                                 want.status, want.fbyte, want.last, want.flen);
                        $display("          got st=%0d byte=%02h last=%0d len=%0d",
                                 got.status, got.fbyte, got.last, got.flen);
                    end
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int r;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // disarmed, unused command, a clean frame, arm while armed, timeout,
        // then a frame whose declared length runs past its stored bytes
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'hA5, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_TICK, 8'hFF, 1'b0, 16'h0});
        stim_rows.push_back({CMD_UNUSED,         8'hA5, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_ARM,  8'h00, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'hA5, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'h01, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'h02, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'hFF, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'h00, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'hFC, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'h5A, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_TICK, 8'h00, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_ARM,  8'hFF, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_TICK, 8'h00, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_ARM,  8'h00, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_TICK, 8'h00, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_TICK, 8'h00, 1'b1,
                             xcfr_pkg::JOB_TIMEOUT, 8'h00, 1'b1, 6'd0});
        stim_rows.push_back({xcfr_pkg::CMD_ARM,  8'h00, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'hA5, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'h6A, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'h30, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'h77, 1'b0, 16'h0});
        stim_rows.push_back({xcfr_pkg::CMD_BYTE, 8'h5A, 1'b0, 16'h0});

        cfg_write(xcfr_pkg::REG_HEAD, 32'h0000_00A5);
        cfg_write(xcfr_pkg::REG_TAIL, 32'h0000_005A);
        cfg_write(xcfr_pkg::REG_TIMEOUT, 32'd2);
        @(negedge i_clk);
        cfg_en <= 1'b0;
        for (r = 0; r < stim_rows.size(); r++)
            push_word(stim_rows[r].cmd, stim_rows[r].rx, stim_rows[r].typed,
                      stim_rows[r].word);

        run_phase(8'h00, 8'h00, 32'd0, 0, 0, 50);
        run_phase(8'hFF, 8'hFF, 32'hFFFF_FFFF, 51, 0, 50);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  32'($urandom_range(1, 6)), 0, 51, 50);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  xcfr_pkg::TIMEOUT_RESET, 27, 27, 50);
        settle();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
